// File: rtl/lfss_pkg.sv
// shared types and constants of the load file symbol stripper
package lfss_pkg;

   localparam logic [31:0] BLK_NAME        = 32'd1000;
   localparam logic [31:0] BLK_CODE        = 32'd1001;
   localparam logic [31:0] BLK_DATA        = 32'd1002;
   localparam logic [31:0] BLK_BSS         = 32'd1003;
   localparam logic [31:0] BLK_RELOC32     = 32'd1004;
   localparam logic [31:0] BLK_SYMBOL      = 32'd1008;
   localparam logic [31:0] BLK_DEBUG       = 32'd1009;
   localparam logic [31:0] BLK_END         = 32'd1010;
   localparam logic [31:0] BLK_HEADER      = 32'd1011;
   localparam logic [31:0] BLK_RELOC32SHRT = 32'd1020;

   localparam logic [23:0] SYM_MAX = 24'hffffff;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOT_EXEC = 2'd1;
   localparam logic [1:0] ST_BAD_HUNK = 2'd2;
   localparam logic [1:0] ST_AFTER    = 2'd3;

   typedef enum logic [4:0] {
      PH_MAGIC, PH_HDR, PH_TAB0, PH_TAB1, PH_TAB2, PH_SIZES, PH_HTYPE,
      PH_NAME_LEN, PH_NAME_SKIP, PH_CD_LEN, PH_CD_COPY, PH_BSS_LEN,
      PH_DBG_LEN, PH_DBG_SKIP, PH_TTYPE, PH_SYM_LEN, PH_SYM_NAME, PH_SYM_VAL,
      PH_R32_CNT, PH_R32_HUNK, PH_R32_OFS, PH_RS_CNT, PH_RS_HUNK, PH_RS_OFS,
      PH_RS_PAD, PH_DONE, PH_ERR1, PH_ERR2
   } phase_type;

   typedef enum logic [1:0] {
      RES_NONE, RES_DROP, RES_SINGLE, RES_PAIR
   } res_kind_type;

   typedef struct packed {
      logic [15:0] word0;
      logic [15:0] word1;
      logic        two;
      logic        data_valid;
      logic [1:0]  status;
      logic [23:0] symbols;
      logic        all_done;
   } rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// File: rtl/lfss_front.sv
// parser: rebuilds longwords, walks the hunk structure, builds result records
module lfss_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [15:0]     in_halfword,
   input  logic            start_of_file,
   output logic            push,
   output lfss_pkg::rec_type rec
);

   lfss_pkg::phase_type phase_ff, phase_in, ph;
   logic [15:0] hold_ff, hold_in, hold_c;
   logic        hp_ff, hp_in, hp_c;
   logic [31:0] wl_ff, wl_in, wl_c;
   logic [31:0] hl_ff, hl_in, hl_c;
   logic        par_ff, par_in, par_c;
   logic [23:0] sc_ff, sc_in, sc_c;
   logic [31:0] fh_ff, fh_in, fh_c;
   lfss_pkg::res_kind_type kind;
   logic [31:0] v, n;
   logic        keep;

   always_comb begin
      ph     = start_of_file ? lfss_pkg::PH_MAGIC : phase_ff;
      hold_c = start_of_file ? 16'd0 : hold_ff;
      hp_c   = start_of_file ? 1'b0 : hp_ff;
      wl_c   = start_of_file ? 32'd0 : wl_ff;
      hl_c   = start_of_file ? 32'd0 : hl_ff;
      par_c  = start_of_file ? 1'b0 : par_ff;
      sc_c   = start_of_file ? 24'd0 : sc_ff;
      fh_c   = start_of_file ? 32'd0 : fh_ff;
   end

   // next state
   always_comb begin
      phase_in = ph;
      hold_in  = hold_c;
      hp_in    = hp_c;
      wl_in    = wl_c;
      hl_in    = hl_c;
      par_in   = par_c;
      sc_in    = sc_c;
      fh_in    = fh_c;
      kind     = lfss_pkg::RES_DROP;
      keep     = 1'b0;
      v        = {hold_c, in_halfword};
      n        = v - fh_c + 32'd1;
      if (n[31]) n = 32'd0;
      if (ph == lfss_pkg::PH_DONE || ph == lfss_pkg::PH_ERR1 ||
          ph == lfss_pkg::PH_ERR2) begin
         kind = lfss_pkg::RES_DROP;
      end else if (ph == lfss_pkg::PH_RS_OFS) begin
         wl_in = wl_c - 32'd1;
         if (wl_c == 32'd1) phase_in = lfss_pkg::PH_RS_CNT;
         kind = lfss_pkg::RES_SINGLE;
      end else if (ph == lfss_pkg::PH_RS_PAD) begin
         phase_in = lfss_pkg::PH_TTYPE;
         kind = lfss_pkg::RES_SINGLE;
      end else if (!hp_c) begin
         hold_in = in_halfword;
         hp_in   = 1'b1;
         kind    = lfss_pkg::RES_NONE;
      end else begin
         hp_in = 1'b0;
         unique case (ph)
            lfss_pkg::PH_MAGIC: begin
               if (v == lfss_pkg::BLK_HEADER) begin
                  phase_in = lfss_pkg::PH_HDR;
                  keep = 1'b1;
               end else phase_in = lfss_pkg::PH_ERR1;
            end
            lfss_pkg::PH_HDR: begin
               if (v == 32'd0) phase_in = lfss_pkg::PH_TAB0;
               keep = 1'b1;
            end
            lfss_pkg::PH_TAB0: begin
               phase_in = lfss_pkg::PH_TAB1;
               keep = 1'b1;
            end
            lfss_pkg::PH_TAB1: begin
               fh_in = v;
               phase_in = lfss_pkg::PH_TAB2;
               keep = 1'b1;
            end
            lfss_pkg::PH_TAB2: begin
               hl_in = n;
               wl_in = n;
               phase_in = (n == 32'd0) ? lfss_pkg::PH_DONE : lfss_pkg::PH_SIZES;
               keep = 1'b1;
            end
            lfss_pkg::PH_SIZES: begin
               wl_in = wl_c - 32'd1;
               if (wl_c == 32'd1)
                  phase_in = (hl_c == 32'd0) ? lfss_pkg::PH_DONE : lfss_pkg::PH_HTYPE;
               keep = 1'b1;
            end
            lfss_pkg::PH_HTYPE: begin
               if (v == lfss_pkg::BLK_NAME) phase_in = lfss_pkg::PH_NAME_LEN;
               else if (v == lfss_pkg::BLK_CODE || v == lfss_pkg::BLK_DATA) begin
                  phase_in = lfss_pkg::PH_CD_LEN;
                  keep = 1'b1;
               end else if (v == lfss_pkg::BLK_BSS) begin
                  phase_in = lfss_pkg::PH_BSS_LEN;
                  keep = 1'b1;
               end else if (v == lfss_pkg::BLK_DEBUG) phase_in = lfss_pkg::PH_DBG_LEN;
               else phase_in = lfss_pkg::PH_ERR2;
            end
            lfss_pkg::PH_NAME_LEN: begin
               wl_in = v;
               phase_in = (v == 32'd0) ? lfss_pkg::PH_HTYPE : lfss_pkg::PH_NAME_SKIP;
            end
            lfss_pkg::PH_NAME_SKIP: begin
               wl_in = wl_c - 32'd1;
               if (wl_c == 32'd1) phase_in = lfss_pkg::PH_HTYPE;
            end
            lfss_pkg::PH_CD_LEN: begin
               wl_in = v;
               phase_in = (v == 32'd0) ? lfss_pkg::PH_TTYPE : lfss_pkg::PH_CD_COPY;
               keep = 1'b1;
            end
            lfss_pkg::PH_CD_COPY: begin
               wl_in = wl_c - 32'd1;
               if (wl_c == 32'd1) phase_in = lfss_pkg::PH_TTYPE;
               keep = 1'b1;
            end
            lfss_pkg::PH_BSS_LEN: begin
               phase_in = lfss_pkg::PH_TTYPE;
               keep = 1'b1;
            end
            lfss_pkg::PH_DBG_LEN: begin
               wl_in = v;
               phase_in = (v == 32'd0) ? lfss_pkg::PH_TTYPE : lfss_pkg::PH_DBG_SKIP;
            end
            lfss_pkg::PH_DBG_SKIP: begin
               wl_in = wl_c - 32'd1;
               if (wl_c == 32'd1) phase_in = lfss_pkg::PH_TTYPE;
            end
            lfss_pkg::PH_TTYPE: begin
               if (v == lfss_pkg::BLK_END) begin
                  hl_in = hl_c - 32'd1;
                  phase_in = (hl_c == 32'd1) ? lfss_pkg::PH_DONE : lfss_pkg::PH_HTYPE;
                  keep = 1'b1;
               end else if (v == lfss_pkg::BLK_DEBUG) phase_in = lfss_pkg::PH_DBG_LEN;
               else if (v == lfss_pkg::BLK_SYMBOL) phase_in = lfss_pkg::PH_SYM_LEN;
               else if (v == lfss_pkg::BLK_RELOC32) begin
                  phase_in = lfss_pkg::PH_R32_CNT;
                  keep = 1'b1;
               end else if (v == lfss_pkg::BLK_RELOC32SHRT) begin
                  par_in = 1'b0;
                  phase_in = lfss_pkg::PH_RS_CNT;
                  keep = 1'b1;
               end else phase_in = lfss_pkg::PH_ERR2;
            end
            lfss_pkg::PH_SYM_LEN: begin
               if (v[23:0] == 24'd0) phase_in = lfss_pkg::PH_TTYPE;
               else begin
                  if (sc_c != lfss_pkg::SYM_MAX) sc_in = sc_c + 24'd1;
                  wl_in = {8'd0, v[23:0]};
                  phase_in = lfss_pkg::PH_SYM_NAME;
               end
            end
            lfss_pkg::PH_SYM_NAME: begin
               wl_in = wl_c - 32'd1;
               if (wl_c == 32'd1) phase_in = lfss_pkg::PH_SYM_VAL;
            end
            lfss_pkg::PH_SYM_VAL: phase_in = lfss_pkg::PH_SYM_LEN;
            lfss_pkg::PH_R32_CNT: begin
               if (v == 32'd0) phase_in = lfss_pkg::PH_TTYPE;
               else begin
                  wl_in = v;
                  phase_in = lfss_pkg::PH_R32_HUNK;
               end
               keep = 1'b1;
            end
            lfss_pkg::PH_R32_HUNK: begin
               phase_in = lfss_pkg::PH_R32_OFS;
               keep = 1'b1;
            end
            lfss_pkg::PH_R32_OFS: begin
               wl_in = wl_c - 32'd1;
               if (wl_c == 32'd1) phase_in = lfss_pkg::PH_R32_CNT;
               keep = 1'b1;
            end
            lfss_pkg::PH_RS_CNT: begin
               if (v == 32'd0)
                  phase_in = par_c ? lfss_pkg::PH_RS_PAD : lfss_pkg::PH_TTYPE;
               else begin
                  wl_in = v;
                  par_in = par_c ^ v[0];
                  phase_in = lfss_pkg::PH_RS_HUNK;
               end
               keep = 1'b1;
            end
            lfss_pkg::PH_RS_HUNK: begin
               phase_in = lfss_pkg::PH_RS_OFS;
               keep = 1'b1;
            end
            default: keep = 1'b0;
         endcase
         kind = keep ? lfss_pkg::RES_PAIR : lfss_pkg::RES_DROP;
      end
   end

   // result record
   always_comb begin
      push = accept && (kind != lfss_pkg::RES_NONE);
      rec.word1      = in_halfword;
      rec.two        = (kind == lfss_pkg::RES_PAIR);
      rec.data_valid = (kind == lfss_pkg::RES_PAIR) || (kind == lfss_pkg::RES_SINGLE);
      unique case (kind)
         lfss_pkg::RES_PAIR:   rec.word0 = hold_c;
         lfss_pkg::RES_SINGLE: rec.word0 = in_halfword;
         default:              rec.word0 = 16'd0;
      endcase
      if (ph == lfss_pkg::PH_DONE)            rec.status = lfss_pkg::ST_AFTER;
      else if (phase_in == lfss_pkg::PH_ERR1) rec.status = lfss_pkg::ST_NOT_EXEC;
      else if (phase_in == lfss_pkg::PH_ERR2) rec.status = lfss_pkg::ST_BAD_HUNK;
      else                                    rec.status = lfss_pkg::ST_OK;
      rec.symbols  = sc_in;
      rec.all_done = (phase_in == lfss_pkg::PH_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lfss_pkg::PH_MAGIC;
         hold_ff  <= 16'd0;
         hp_ff    <= 1'b0;
         wl_ff    <= 32'd0;
         hl_ff    <= 32'd0;
         par_ff   <= 1'b0;
         sc_ff    <= 24'd0;
         fh_ff    <= 32'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         hold_ff  <= hold_in;
         hp_ff    <= hp_in;
         wl_ff    <= wl_in;
         hl_ff    <= hl_in;
         par_ff   <= par_in;
         sc_ff    <= sc_in;
         fh_ff    <= fh_in;
      end
   end

endmodule

// File: rtl/lfss_queue.sv
// four-entry record queue between parser and output stage
module lfss_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lfss_pkg::rec_type push_rec,
   input  logic              pop,
   output lfss_pkg::rec_type head,
   output lfss_pkg::qstat_type stat
);

   lfss_pkg::rec_type mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff, cnt_in;

   assign head       = mem_ff[rp_ff];
   assign stat.full  = (cnt_ff == 3'd4);
   assign stat.empty = (cnt_ff == 3'd0);

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 3'd1;
      else if (pop && !push) cnt_in = cnt_ff - 3'd1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_rec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 2'd0;
         rp_ff  <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop)  rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: rtl/lfss_back.sv
// output stage: splits records into halfword responses
module lfss_back (
   input  logic                clock,
   input  logic                reset,
   input  lfss_pkg::rec_type   head,
   input  lfss_pkg::qstat_type stat,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_out_halfword,
   output logic                rsp_data_valid,
   output logic [1:0]          rsp_status,
   output logic [23:0]         rsp_symbols_stripped,
   output logic                rsp_all_done
);

   logic        valid_ff, valid_in;
   logic        sec_ff, sec_in;
   logic        load;
   logic [15:0] hw_ff;
   logic        dv_ff;
   logic [1:0]  st_ff;
   logic [23:0] sym_ff;
   logic        done_ff;

   always_comb begin
      load     = (!valid_ff || rsp_ready) && !stat.empty;
      pop      = load && (sec_ff || !head.two);
      sec_in   = sec_ff;
      valid_in = valid_ff;
      if (valid_ff && rsp_ready) valid_in = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         sec_in   = !sec_ff && head.two;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sec_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sec_ff   <= sec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hw_ff   <= sec_ff ? head.word1 : head.word0;
         dv_ff   <= head.data_valid;
         st_ff   <= head.status;
         sym_ff  <= head.symbols;
         done_ff <= head.all_done;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_out_halfword     = hw_ff;
   assign rsp_data_valid       = dv_ff;
   assign rsp_status           = st_ff;
   assign rsp_symbols_stripped = sym_ff;
   assign rsp_all_done         = done_ff;

endmodule

// File: rtl/load_file_symbol_stripper.sv
// top level of the hunk load file symbol stripper
// usage:
//   req_ channel carries one halfword of the load file per request, most
//   significant half of each longword first; req_start_of_file restarts
//   parsing at the header magic with that halfword.
//   rsp_ channel gives the halfwords kept for the stripped file together
//   with status, running symbol count and the all-done flag; dropped
//   longwords and error or after-end requests give one response with
//   rsp_data_valid low, a kept longword gives two responses.
//   a response passes the record queue, then the output register once free.
//   throughput: one request per cycle while the four-entry record queue
//   is not full; the output stage sends one halfword per cycle while
//   rsp_ready is high, so a kept longword (two requests, two responses)
//   flows at full rate.
//   reset clears parser state, queue and output valid flag; no request or
//   response is in flight afterwards.
//   when the receiver stalls the queue fills and req_ready falls; the
//   offered response holds until taken.
module load_file_symbol_stripper (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_in_halfword,
   input  logic        req_start_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_out_halfword,
   output logic        rsp_data_valid,
   output logic [1:0]  rsp_status,
   output logic [23:0] rsp_symbols_stripped,
   output logic        rsp_all_done
);

   logic                accept;
   logic                push;
   logic                pop;
   lfss_pkg::rec_type   rec;
   lfss_pkg::rec_type   head;
   lfss_pkg::qstat_type stat;

   assign req_ready = !stat.full;
   assign accept    = req_valid && req_ready;

   lfss_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_halfword   (req_in_halfword),
      .start_of_file (req_start_of_file),
      .push          (push),
      .rec           (rec)
   );

   lfss_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (rec),
      .pop      (pop),
      .head     (head),
      .stat     (stat)
   );

   lfss_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head                 (head),
      .stat                 (stat),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_out_halfword     (rsp_out_halfword),
      .rsp_data_valid       (rsp_data_valid),
      .rsp_status           (rsp_status),
      .rsp_symbols_stripped (rsp_symbols_stripped),
      .rsp_all_done         (rsp_all_done)
   );

   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(stat.full && stat.empty))
      else $error("queue both full and empty");

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> !stat.empty)
      else $error("pop from empty queue");

   a_after_end_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == lfss_pkg::ST_AFTER) |-> rsp_all_done)
      else $error("after-end status without done");

   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != lfss_pkg::ST_OK) |->
      (!rsp_data_valid && rsp_out_halfword == 16'd0))
      else $error("data on error response");

endmodule

// File: tb/sv/tb_load_file_symbol_stripper.sv
// testbench of the load file symbol stripper: random hunk files checked against a predictor
module tb_load_file_symbol_stripper;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [15:0] hw;
      logic        sof;
      logic        pause;
   } halfword_req_type;

   typedef struct {
      logic [15:0] hw;
      logic        dv;
      logic [1:0]  st;
      logic [23:0] sym;
      logic        done;
   } kept_half_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_in_halfword = '0;
   logic        req_start_of_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_out_halfword;
   logic        rsp_data_valid;
   logic [1:0]  rsp_status;
   logic [23:0] rsp_symbols_stripped;
   logic        rsp_all_done;

   halfword_req_type pend_q[$];
   kept_half_type    kept_q[$];
   halfword_req_type cur_req;

   int n_fail = 0;
   int n_checked = 0;
   int n_accepted = 0;
   int n_files = 0;
   int req_gap = 0;
   int rsp_gap = 0;

   // predictor state
   lfss_pkg::phase_type ph;
   logic [15:0] hold_hi;
   logic        half_pos;
   logic [31:0] words_left;
   logic [31:0] hunks_left;
   logic        rs_parity;
   logic [23:0] sym_cnt;
   logic [31:0] first_hunk;

   load_file_symbol_stripper dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic clear_parser();
      ph = lfss_pkg::PH_MAGIC;
      hold_hi = '0;
      half_pos = 1'b0;
      words_left = '0;
      hunks_left = '0;
      rs_parity = 1'b0;
      sym_cnt = '0;
      first_hunk = '0;
   endtask

   task automatic push_kept(input logic [15:0] hw, input logic dv);
      kept_half_type k;
      k.hw = dv ? hw : 16'h0;
      k.dv = dv;
      k.st = (ph == lfss_pkg::PH_ERR1) ? lfss_pkg::ST_NOT_EXEC :
             (ph == lfss_pkg::PH_ERR2) ? lfss_pkg::ST_BAD_HUNK : lfss_pkg::ST_OK;
      k.sym = sym_cnt;
      k.done = (ph == lfss_pkg::PH_DONE);
      kept_q.push_back(k);
   endtask

   function automatic lfss_pkg::phase_type after_hunks();
      return (hunks_left == 0) ? lfss_pkg::PH_DONE : lfss_pkg::PH_HTYPE;
   endfunction

   function automatic logic keep_longword(input logic [31:0] v);
      logic [31:0] n;
      case (ph)
         lfss_pkg::PH_MAGIC: begin
            if (v == lfss_pkg::BLK_HEADER) begin
               ph = lfss_pkg::PH_HDR;
               return 1'b1;
            end
            ph = lfss_pkg::PH_ERR1;
            return 1'b0;
         end
         lfss_pkg::PH_HDR: begin
            if (v == 0) ph = lfss_pkg::PH_TAB0;
            return 1'b1;
         end
         lfss_pkg::PH_TAB0: begin
            ph = lfss_pkg::PH_TAB1;
            return 1'b1;
         end
         lfss_pkg::PH_TAB1: begin
            first_hunk = v;
            ph = lfss_pkg::PH_TAB2;
            return 1'b1;
         end
         lfss_pkg::PH_TAB2: begin
            n = v - first_hunk + 32'd1;
            if (n[31]) n = 0;
            hunks_left = n;
            words_left = n;
            ph = (n == 0) ? after_hunks() : lfss_pkg::PH_SIZES;
            return 1'b1;
         end
         lfss_pkg::PH_SIZES: begin
            words_left = words_left - 32'd1;
            if (words_left == 0) ph = after_hunks();
            return 1'b1;
         end
         lfss_pkg::PH_HTYPE: begin
            if (v == lfss_pkg::BLK_NAME) begin
               ph = lfss_pkg::PH_NAME_LEN;
               return 1'b0;
            end
            if (v == lfss_pkg::BLK_CODE || v == lfss_pkg::BLK_DATA) begin
               ph = lfss_pkg::PH_CD_LEN;
               return 1'b1;
            end
            if (v == lfss_pkg::BLK_BSS) begin
               ph = lfss_pkg::PH_BSS_LEN;
               return 1'b1;
            end
            if (v == lfss_pkg::BLK_DEBUG) begin
               ph = lfss_pkg::PH_DBG_LEN;
               return 1'b0;
            end
            ph = lfss_pkg::PH_ERR2;
            return 1'b0;
         end
         lfss_pkg::PH_NAME_LEN: begin
            words_left = v;
            ph = (v == 0) ? lfss_pkg::PH_HTYPE : lfss_pkg::PH_NAME_SKIP;
            return 1'b0;
         end
         lfss_pkg::PH_NAME_SKIP: begin
            words_left = words_left - 32'd1;
            if (words_left == 0) ph = lfss_pkg::PH_HTYPE;
            return 1'b0;
         end
         lfss_pkg::PH_CD_LEN: begin
            words_left = v;
            ph = (v == 0) ? lfss_pkg::PH_TTYPE : lfss_pkg::PH_CD_COPY;
            return 1'b1;
         end
         lfss_pkg::PH_CD_COPY: begin
            words_left = words_left - 32'd1;
            if (words_left == 0) ph = lfss_pkg::PH_TTYPE;
            return 1'b1;
         end
         lfss_pkg::PH_BSS_LEN: begin
            ph = lfss_pkg::PH_TTYPE;
            return 1'b1;
         end
         lfss_pkg::PH_DBG_LEN: begin
            words_left = v;
            ph = (v == 0) ? lfss_pkg::PH_TTYPE : lfss_pkg::PH_DBG_SKIP;
            return 1'b0;
         end
         lfss_pkg::PH_DBG_SKIP: begin
            words_left = words_left - 32'd1;
            if (words_left == 0) ph = lfss_pkg::PH_TTYPE;
            return 1'b0;
         end
         lfss_pkg::PH_TTYPE: begin
            if (v == lfss_pkg::BLK_END) begin
               hunks_left = hunks_left - 32'd1;
               ph = after_hunks();
               return 1'b1;
            end
            if (v == lfss_pkg::BLK_DEBUG) begin
               ph = lfss_pkg::PH_DBG_LEN;
               return 1'b0;
            end
            if (v == lfss_pkg::BLK_SYMBOL) begin
               ph = lfss_pkg::PH_SYM_LEN;
               return 1'b0;
            end
            if (v == lfss_pkg::BLK_RELOC32) begin
               ph = lfss_pkg::PH_R32_CNT;
               return 1'b1;
            end
            if (v == lfss_pkg::BLK_RELOC32SHRT) begin
               rs_parity = 1'b0;
               ph = lfss_pkg::PH_RS_CNT;
               return 1'b1;
            end
            ph = lfss_pkg::PH_ERR2;
            return 1'b0;
         end
         lfss_pkg::PH_SYM_LEN: begin
            if (v[23:0] == 0) begin
               ph = lfss_pkg::PH_TTYPE;
               return 1'b0;
            end
            if (sym_cnt != lfss_pkg::SYM_MAX) sym_cnt = sym_cnt + 24'd1;
            words_left = {8'h0, v[23:0]};
            ph = lfss_pkg::PH_SYM_NAME;
            return 1'b0;
         end
         lfss_pkg::PH_SYM_NAME: begin
            words_left = words_left - 32'd1;
            if (words_left == 0) ph = lfss_pkg::PH_SYM_VAL;
            return 1'b0;
         end
         lfss_pkg::PH_SYM_VAL: begin
            ph = lfss_pkg::PH_SYM_LEN;
            return 1'b0;
         end
         lfss_pkg::PH_R32_CNT: begin
            if (v == 0) begin
               ph = lfss_pkg::PH_TTYPE;
               return 1'b1;
            end
            words_left = v;
            ph = lfss_pkg::PH_R32_HUNK;
            return 1'b1;
         end
         lfss_pkg::PH_R32_HUNK: begin
            ph = lfss_pkg::PH_R32_OFS;
            return 1'b1;
         end
         lfss_pkg::PH_R32_OFS: begin
            words_left = words_left - 32'd1;
            if (words_left == 0) ph = lfss_pkg::PH_R32_CNT;
            return 1'b1;
         end
         lfss_pkg::PH_RS_CNT: begin
            if (v == 0) begin
               ph = rs_parity ? lfss_pkg::PH_RS_PAD : lfss_pkg::PH_TTYPE;
               return 1'b1;
            end
            words_left = v;
            rs_parity = rs_parity ^ v[0];
            ph = lfss_pkg::PH_RS_HUNK;
            return 1'b1;
         end
         lfss_pkg::PH_RS_HUNK: begin
            ph = lfss_pkg::PH_RS_OFS;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic strip_halfword(input logic [15:0] hw, input logic sof);
      kept_half_type k;
      logic [15:0] hi;
      if (sof) clear_parser();
      if (ph == lfss_pkg::PH_DONE) begin
         push_kept(16'h0, 1'b0);
         k = kept_q.pop_back();
         k.st = lfss_pkg::ST_AFTER;
         kept_q.push_back(k);
      end else if (ph == lfss_pkg::PH_ERR1 || ph == lfss_pkg::PH_ERR2) begin
         push_kept(16'h0, 1'b0);
      end else if (ph == lfss_pkg::PH_RS_OFS) begin
         words_left = words_left - 32'd1;
         if (words_left == 0) ph = lfss_pkg::PH_RS_CNT;
         push_kept(hw, 1'b1);
      end else if (ph == lfss_pkg::PH_RS_PAD) begin
         ph = lfss_pkg::PH_TTYPE;
         push_kept(hw, 1'b1);
      end else if (!half_pos) begin
         hold_hi = hw;
         half_pos = 1'b1;
      end else begin
         half_pos = 1'b0;
         hi = hold_hi;
         if (keep_longword({hi, hw})) begin
            push_kept(hi, 1'b1);
            push_kept(hw, 1'b1);
         end else begin
            push_kept(16'h0, 1'b0);
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      n_fail++;
   endtask

   function automatic int pick_gap();
      int r;
      if ((n_accepted / 150) % 3 == 1) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver
   always @(posedge clock) begin
      logic nxt_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         nxt_valid = req_valid;
         if (req_valid && req_ready) begin
            strip_halfword(cur_req.hw, cur_req.sof);
            n_accepted++;
            nxt_valid = 1'b0;
            req_gap = pick_gap();
         end
         if (!nxt_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pend_q.size() > 0) begin
               if (pend_q[0].pause) begin
                  if (kept_q.size() == 0) void'(pend_q.pop_front());
               end else begin
                  cur_req = pend_q.pop_front();
                  req_in_halfword <= cur_req.hw;
                  req_start_of_file <= cur_req.sof;
                  nxt_valid = 1'b1;
               end
            end
         end
         req_valid <= nxt_valid;
      end
   end

   // monitor
   always @(posedge clock) begin
      kept_half_type k;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_checked++;
            if (kept_q.size() == 0) begin
               report_mismatch("unexpected response", 32'(rsp_out_halfword), 32'd0);
            end else begin
               k = kept_q.pop_front();
               if (rsp_out_halfword !== k.hw)
                  report_mismatch("halfword", 32'(rsp_out_halfword), 32'(k.hw));
               if (rsp_data_valid !== k.dv)
                  report_mismatch("data_valid", 32'(rsp_data_valid), 32'(k.dv));
               if (rsp_status !== k.st)
                  report_mismatch("status", 32'(rsp_status), 32'(k.st));
               if (rsp_symbols_stripped !== k.sym)
                  report_mismatch("symbols", 32'(rsp_symbols_stripped), 32'(k.sym));
               if (rsp_all_done !== k.done)
                  report_mismatch("all_done", 32'(rsp_all_done), 32'(k.done));
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_gap = pick_gap();
            rsp_ready <= (rsp_gap == 0);
         end
      end
   end

   task automatic put_half(input logic [15:0] h, input logic s = 1'b0);
      pend_q.push_back('{h, s, 1'b0});
   endtask

   task automatic put_long(input logic [31:0] v, input logic s = 1'b0);
      put_half(v[31:16], s);
      put_half(v[15:0]);
   endtask

   task automatic put_pause();
      pend_q.push_back('{16'h0, 1'b0, 1'b1});
   endtask

   task automatic put_tail_block();
      int c, total;
      case ($urandom_range(0, 3))
         0: begin
            put_long(lfss_pkg::BLK_RELOC32);
            repeat ($urandom_range(0, 2)) begin
               c = $urandom_range(1, 3);
               put_long(c);
               put_long($urandom);
               repeat (c) put_long($urandom);
            end
            put_long(0);
         end
         1: begin
            total = 0;
            put_long(lfss_pkg::BLK_RELOC32SHRT);
            repeat ($urandom_range(0, 2)) begin
               c = $urandom_range(1, 4);
               put_long(c);
               put_long($urandom);
               repeat (c) put_half(16'($urandom));
               total += c;
            end
            put_long(0);
            if (total % 2) put_half(16'($urandom));
         end
         2: begin
            put_long(lfss_pkg::BLK_SYMBOL);
            repeat ($urandom_range(0, 3)) begin
               c = $urandom_range(1, 2);
               put_long({8'($urandom), 24'(c)});
               repeat (c) put_long($urandom);
               put_long($urandom);
            end
            put_long({8'($urandom), 24'h0});
         end
         default: begin
            c = $urandom_range(0, 2);
            put_long(lfss_pkg::BLK_DEBUG);
            put_long(c);
            repeat (c) put_long($urandom);
         end
      endcase
   endtask

   task automatic put_hunk();
      int c;
      if ($urandom_range(0, 2) == 0) begin
         c = $urandom_range(0, 2);
         put_long(lfss_pkg::BLK_NAME);
         put_long(c);
         repeat (c) put_long($urandom);
      end
      if ($urandom_range(0, 4) == 0) begin
         c = $urandom_range(0, 2);
         put_long(lfss_pkg::BLK_DEBUG);
         put_long(c);
         repeat (c) put_long($urandom);
      end
      case ($urandom_range(0, 2))
         0, 1: begin
            c = $urandom_range(0, 4);
            put_long($urandom_range(0, 1) ? lfss_pkg::BLK_CODE : lfss_pkg::BLK_DATA);
            put_long(c);
            repeat (c) put_long($urandom);
         end
         default: begin
            put_long(lfss_pkg::BLK_BSS);
            put_long($urandom);
         end
      endcase
      repeat ($urandom_range(0, 3)) put_tail_block();
      put_long(lfss_pkg::BLK_END);
   endtask

   // broken: 0 bad magic, 1 bad hunk type, 2 bad tail type, 3 cut short
   task automatic put_file(input int hunks, input int broken = -1);
      logic [31:0] first, word;
      n_files++;
      if (broken == 0) begin
         do word = $urandom; while (word == lfss_pkg::BLK_HEADER);
         put_long(word, 1'b1);
         repeat ($urandom_range(1, 4)) put_half(16'($urandom));
         return;
      end
      put_long(lfss_pkg::BLK_HEADER, 1'b1);
      repeat ($urandom_range(0, 2)) put_long($urandom | 32'h1);
      put_long(0);
      put_long($urandom);
      first = $urandom;
      put_long(first);
      if (hunks == 0)
         put_long($urandom_range(0, 1) ? first - 1 : first - 1 - $urandom_range(1, 1000));
      else
         put_long(first + hunks - 1);
      repeat (hunks) put_long($urandom);
      for (int i = 0; i < hunks; i++) begin
         if (broken == 1 && i == hunks - 1) begin
            put_long($urandom_range(0, 1) ? $urandom_range(1004, 1008) : $urandom);
            repeat ($urandom_range(1, 4)) put_half(16'($urandom));
            return;
         end
         if (broken == 2 && i == hunks - 1) begin
            put_long(lfss_pkg::BLK_CODE);
            put_long(0);
            put_long($urandom_range(1000, 1003));
            repeat ($urandom_range(1, 4)) put_half(16'($urandom));
            return;
         end
         if (broken == 3 && i == hunks - 1) begin
            put_long(lfss_pkg::BLK_CODE);
            put_long(5);
            put_half(16'($urandom));
            return;
         end
         put_hunk();
      end
      repeat ($urandom_range(0, 3)) put_half(16'($urandom));
   endtask

   initial begin
      clear_parser();
      // directed: bad magic, zero hunks, stray input after end, a full hunk, a bad hunk type
      put_file(0, 0);
      put_file(0);
      put_half(16'hffff);
      put_half(16'h0000);
      put_pause();
      put_file(1);
      put_file(1, 1);
      while (pend_q.size() < 750) begin
         if ($urandom_range(0, 9) == 0) put_pause();
         if ($urandom_range(0, 4) == 0)
            put_file($urandom_range(1, 2), $urandom_range(0, 3));
         else
            put_file($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 3));
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (pend_q.size() != 0 || req_valid) @(posedge clock);
      while (kept_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("%0d files, %0d requests sent, %0d responses checked", n_files, n_accepted,
               n_checked);
      $display("covered magic errors, bad hunk types, relocations, symbols and trailing input");
      if (n_fail == 0 && kept_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

// File: files.f
rtl/lfss_pkg.sv
rtl/lfss_front.sv
rtl/lfss_queue.sv
rtl/lfss_back.sv
rtl/load_file_symbol_stripper.sv
tb/sv/tb_load_file_symbol_stripper.sv
